>>> rtl/core/box_overlap_suppression_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box overlap suppression block
// Each macro assumes a clock and a synchronous active-high reset argument.
// ----------------------------------------------------------------------------
`ifndef BOX_OVERLAP_SUPPRESSION_ASSERT_SVH
`define BOX_OVERLAP_SUPPRESSION_ASSERT_SVH

// Same-cycle implication
`define BOS_ASSERT_HOLDS(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BOS_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bos_pkg.sv
// ----------------------------------------------------------------------------
// bos_pkg
// Shared types, widths and constants of the box overlap suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package bos_pkg;

  localparam int EDGE_W     = 18;
  localparam int SCORE_W    = 17;
  localparam int LABEL_W    = 8;
  localparam int THR_W      = 17;
  localparam int FRAME_W    = 13;
  localparam int INDEX_W    = 5;
  localparam int ROI_W      = 13;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int THR_FRAC   = 16;

  localparam int MAX_BOXES_DEF  = 32;
  localparam int COORD_FRAC_DEF = 16;

  localparam logic [PCT_W-1:0]   PCT_SCALE    = 7'd100;
  localparam logic [ROI_W-1:0]   ROI_MAX      = 13'd8191;
  localparam logic [LABEL_W-1:0] PERSON_LABEL = 8'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IOU_THR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTAIN_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H     = 3'd4;

  // Register reset values
  localparam logic [THR_W-1:0]   SCORE_THR_RST   = 17'd19661;
  localparam logic [THR_W-1:0]   IOU_THR_RST     = 17'd26214;
  localparam logic [THR_W-1:0]   CONTAIN_THR_RST = 17'd62259;
  localparam logic [FRAME_W-1:0] FRAME_W_RST     = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_H_RST     = 13'd480;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCORE,
    ST_CMP,
    ST_DRAIN,
    ST_EMIT
  } bos_state_t;

  // One stored detection, edges as raw two's complement
  typedef struct packed {
    logic [EDGE_W-1:0]  top;
    logic [EDGE_W-1:0]  left;
    logic [EDGE_W-1:0]  bottom;
    logic [EDGE_W-1:0]  right;
    logic [SCORE_W-1:0] score;
    logic [LABEL_W-1:0] label;
  } bos_box_t;

  // One result request into the output pipeline
  typedef struct packed {
    bos_box_t           box;
    logic [INDEX_W-1:0] index;
    logic               none;
    logic               last;
  } bos_rec_t;

  function automatic logic signed [EDGE_W-1:0] edge_min(input logic [EDGE_W-1:0] a,
                                                         input logic [EDGE_W-1:0] b);
    return ($signed(a) < $signed(b)) ? $signed(a) : $signed(b);
  endfunction

  function automatic logic signed [EDGE_W-1:0] edge_max(input logic [EDGE_W-1:0] a,
                                                         input logic [EDGE_W-1:0] b);
    return ($signed(a) > $signed(b)) ? $signed(a) : $signed(b);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bos_cell.sv
// ----------------------------------------------------------------------------
// bos_cell
// One cell of the box ring: holds a box, its index and an occupied flag,
// and takes its neighbour's contents whenever the ring moves.
// ----------------------------------------------------------------------------
`default_nettype none

module bos_cell import bos_pkg::*; #(
  parameter int TAG_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             clear,
  input  bos_box_t         nb_box,
  input  logic [TAG_W-1:0] nb_tag,
  input  logic             nb_used,
  output bos_box_t         box,
  output logic [TAG_W-1:0] tag,
  output logic             used
);

  // Take the neighbour's payload
  always_ff @(posedge clk) begin
    if (shift) begin
      box <= nb_box;
      tag <= nb_tag;
    end
  end

  // Occupied flag: drop on reset and at the end of a set
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      used <= 1'b0;
    end else if (shift) begin
      used <= nb_used;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bos_overlap.sv
// ----------------------------------------------------------------------------
// bos_overlap
// Pipelined overlap test of a reference box against a candidate box:
// containment of either area, or IoU above threshold by cross-multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module bos_overlap import bos_pkg::*; #(
  parameter int TAG_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             issue,
  input  logic [TAG_W-1:0] ref_tag,
  input  logic [TAG_W-1:0] cand_tag,
  input  bos_box_t         ref_box,
  input  bos_box_t         cand_box,
  input  logic [THR_W-1:0] iou_thr,
  input  logic [THR_W-1:0] contain_thr,
  output logic             wr_en,
  output logic [TAG_W-1:0] wr_tag,
  output logic [TAG_W-1:0] wr_ref,
  output logic             busy
);

  localparam int AREA_W = 2 * EDGE_W;
  localparam int PART_W = THR_W + EDGE_W;
  localparam int SUM_W  = AREA_W + 1;
  localparam int HI_W   = SUM_W - EDGE_W;
  localparam int CMP_W  = THR_W + AREA_W + 1;

  logic signed [EDGE_W-1:0] ay0, ay1, ax0, ax1, by0, by1, bx0, bx1;
  logic signed [EDGE_W-1:0] xa, xb, ya, yb;
  logic                     isect;

  logic                     s1_v, s2_v, s3_v, s4_v;
  logic [TAG_W-1:0]         s1_ref, s2_ref, s3_ref, s4_ref;
  logic [TAG_W-1:0]         s1_tag, s2_tag, s3_tag, s4_tag;
  logic [EDGE_W-1:0]        s1_dxa, s1_dya, s1_dxb, s1_dyb, s1_dxi, s1_dyi;
  logic [AREA_W-1:0]        s2_aa, s2_ab, s2_in;
  logic [SUM_W-1:0]         s2_u;
  logic [SUM_W-1:0]         s3_u;
  logic [AREA_W-1:0]        s3_in;
  logic [PART_W-1:0]        s3_ca_lo, s3_ca_hi, s3_cb_lo, s3_cb_hi;
  logic [CMP_W-1:0]         ca, cb, in_sh3;
  logic                     hit_c;
  logic                     s4_hit_c;
  logic [AREA_W-1:0]        s4_in;
  logic [PART_W-1:0]        s4_iu_lo;
  logic [PART_W+HI_W-EDGE_W-1:0] s4_iu_hi;
  logic [CMP_W-1:0]         iu, in_sh4;
  logic                     hit;

  // Normalise corners and find the intersection
  assign ay0 = edge_min(ref_box.top, ref_box.bottom);
  assign ay1 = edge_max(ref_box.top, ref_box.bottom);
  assign ax0 = edge_min(ref_box.left, ref_box.right);
  assign ax1 = edge_max(ref_box.left, ref_box.right);
  assign by0 = edge_min(cand_box.top, cand_box.bottom);
  assign by1 = edge_max(cand_box.top, cand_box.bottom);
  assign bx0 = edge_min(cand_box.left, cand_box.right);
  assign bx1 = edge_max(cand_box.left, cand_box.right);
  assign xa  = (ax0 > bx0) ? ax0 : bx0;
  assign xb  = (ax1 < bx1) ? ax1 : bx1;
  assign ya  = (ay0 > by0) ? ay0 : by0;
  assign yb  = (ay1 < by1) ? ay1 : by1;
  assign isect = (xa <= xb) && (ya <= yb);

  // Stage 1: side lengths
  always_ff @(posedge clk) begin
    s1_ref <= ref_tag;
    s1_tag <= cand_tag;
    s1_dxa <= EDGE_W'(ax1 - ax0);
    s1_dya <= EDGE_W'(ay1 - ay0);
    s1_dxb <= EDGE_W'(bx1 - bx0);
    s1_dyb <= EDGE_W'(by1 - by0);
    s1_dxi <= isect ? EDGE_W'(xb - xa) : '0;
    s1_dyi <= isect ? EDGE_W'(yb - ya) : '0;
  end

  // Stage 2: areas
  always_ff @(posedge clk) begin
    s2_ref <= s1_ref;
    s2_tag <= s1_tag;
    s2_aa  <= s1_dxa * s1_dya;
    s2_ab  <= s1_dxb * s1_dyb;
    s2_in  <= s1_dxi * s1_dyi;
  end

  // Stage 3: union and containment partial products
  assign s2_u = SUM_W'(s2_aa) + SUM_W'(s2_ab) - SUM_W'(s2_in);

  always_ff @(posedge clk) begin
    s3_ref   <= s2_ref;
    s3_tag   <= s2_tag;
    s3_u     <= s2_u;
    s3_in    <= s2_in;
    s3_ca_lo <= contain_thr * s2_aa[EDGE_W-1:0];
    s3_ca_hi <= contain_thr * s2_aa[AREA_W-1:EDGE_W];
    s3_cb_lo <= contain_thr * s2_ab[EDGE_W-1:0];
    s3_cb_hi <= contain_thr * s2_ab[AREA_W-1:EDGE_W];
  end

  // Stage 4: containment compare and IoU partial products
  assign ca     = (CMP_W'(s3_ca_hi) << EDGE_W) + CMP_W'(s3_ca_lo);
  assign cb     = (CMP_W'(s3_cb_hi) << EDGE_W) + CMP_W'(s3_cb_lo);
  assign in_sh3 = CMP_W'(s3_in) << THR_FRAC;
  assign hit_c  = (in_sh3 > ca) || (in_sh3 > cb);

  always_ff @(posedge clk) begin
    s4_ref   <= s3_ref;
    s4_tag   <= s3_tag;
    s4_in    <= s3_in;
    s4_hit_c <= hit_c;
    s4_iu_lo <= iou_thr * s3_u[EDGE_W-1:0];
    s4_iu_hi <= iou_thr * s3_u[SUM_W-1:EDGE_W];
  end

  // IoU compare and flag write-back
  assign iu     = (CMP_W'(s4_iu_hi) << EDGE_W) + CMP_W'(s4_iu_lo);
  assign in_sh4 = CMP_W'(s4_in) << THR_FRAC;
  assign hit    = s4_hit_c || (in_sh4 > iu);

  assign wr_en  = s4_v && hit;
  assign wr_tag = s4_tag;
  assign wr_ref = s4_ref;
  assign busy   = s1_v || s2_v || s3_v || s4_v;

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bos_result.sv
// ----------------------------------------------------------------------------
// bos_result
// Result pipeline: scales a surviving person box to a clamped pixel
// rectangle and a score in percent (else zeros); holds it until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bos_result import bos_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               ready,
  input  bos_rec_t           rec,
  input  logic [FRAME_W-1:0] frame_w,
  input  logic [FRAME_W-1:0] frame_h,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] cand_index,
  output logic               none_kept,
  output logic               is_person,
  output logic [ROI_W-1:0]   roi_x,
  output logic [ROI_W-1:0]   roi_y,
  output logic [ROI_W-1:0]   roi_w,
  output logic [ROI_W-1:0]   roi_h,
  output logic [PCT_W-1:0]   score_percent,
  output logic               last_result
);

  localparam int PROD_W = EDGE_W + FRAME_W + 1;
  localparam int PIX_W  = PROD_W - COORD_FRAC_BITS;
  localparam int PCTP_W = SCORE_W + PCT_W;
  localparam int PCTR_W = PCTP_W - THR_FRAC;

  logic                     a_v, b_v;
  logic [INDEX_W-1:0]       a_idx, b_idx;
  logic                     a_none, b_none, a_last, b_last, a_pers, b_pers;
  logic signed [PROD_W-1:0] a_pl, a_pr, a_pt, a_pb;
  logic [PCTP_W-1:0]        a_pct;
  logic signed [PIX_W-1:0]  b_x0, b_x1, b_y0, b_y1;
  logic [PCTR_W-1:0]        b_pct;
  logic signed [PROD_W-1:0] x0w, x1w, y0w, y1w, w, h, fw, fh;
  logic                     rect_ok;
  logic [ROI_W-1:0]         x_cl, y_cl, w_cl, h_cl;
  logic [PCT_W-1:0]         pct_cl;

  assign ready = !out_valid || out_ready;

  // Truncate a scaled corner toward zero
  function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] sum;
    bias = p[PROD_W-1] ? $signed(PROD_W'((1 << COORD_FRAC_BITS) - 1)) : '0;
    sum  = (p + bias) >>> COORD_FRAC_BITS;
    return sum[PIX_W-1:0];
  endfunction

  // Stage A: scale products
  always_ff @(posedge clk) begin
    if (ready) begin
      a_idx  <= rec.index;
      a_none <= rec.none;
      a_last <= rec.last;
      a_pers <= (rec.box.label == PERSON_LABEL) && !rec.none;
      a_pl   <= $signed(rec.box.left)   * $signed({1'b0, frame_w});
      a_pr   <= $signed(rec.box.right)  * $signed({1'b0, frame_w});
      a_pt   <= $signed(rec.box.top)    * $signed({1'b0, frame_h});
      a_pb   <= $signed(rec.box.bottom) * $signed({1'b0, frame_h});
      a_pct  <= rec.box.score * PCT_SCALE;
    end
  end

  // Stage B: pixel corners
  always_ff @(posedge clk) begin
    if (ready) begin
      b_idx  <= a_idx;
      b_none <= a_none;
      b_last <= a_last;
      b_pers <= a_pers;
      b_x0   <= to_pixel(a_pl);
      b_x1   <= to_pixel(a_pr);
      b_y0   <= to_pixel(a_pt);
      b_y1   <= to_pixel(a_pb);
      b_pct  <= a_pct[PCTP_W-1:THR_FRAC];
    end
  end

  // Rectangle size and clamps
  assign x0w = PROD_W'(b_x0);
  assign x1w = PROD_W'(b_x1);
  assign y0w = PROD_W'(b_y0);
  assign y1w = PROD_W'(b_y1);
  assign w   = x1w - x0w;
  assign h   = y1w - y0w;
  assign fw  = $signed(PROD_W'(frame_w));
  assign fh  = $signed(PROD_W'(frame_h));
  assign rect_ok = b_pers && !w[PROD_W-1] && !h[PROD_W-1];

  always_comb begin
    w_cl = (w > fw) ? frame_w : w[ROI_W-1:0];
    h_cl = (h > fh) ? frame_h : h[ROI_W-1:0];
    if (x0w[PROD_W-1]) begin
      x_cl = '0;
    end else if (x0w > $signed(PROD_W'(ROI_MAX))) begin
      x_cl = ROI_MAX;
    end else begin
      x_cl = x0w[ROI_W-1:0];
    end
    if (y0w[PROD_W-1]) begin
      y_cl = '0;
    end else if (y0w > $signed(PROD_W'(ROI_MAX))) begin
      y_cl = ROI_MAX;
    end else begin
      y_cl = y0w[ROI_W-1:0];
    end
    pct_cl = (b_pct > PCTR_W'(PCT_SCALE)) ? PCT_SCALE : PCT_W'(b_pct);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ready) begin
      cand_index    <= b_idx;
      none_kept     <= b_none;
      last_result   <= b_last;
      is_person     <= rect_ok;
      roi_x         <= rect_ok ? x_cl : '0;
      roi_y         <= rect_ok ? y_cl : '0;
      roi_w         <= rect_ok ? w_cl : '0;
      roi_h         <= rect_ok ? h_cl : '0;
      score_percent <= rect_ok ? pct_cl : '0;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (ready) begin
      a_v       <= push;
      b_v       <= a_v;
      out_valid <= b_v;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/box_overlap_suppression.sv
// ----------------------------------------------------------------------------
// box_overlap_suppression
// Non-maximum suppression of a set of detection boxes by IoU and containment.
// ----------------------------------------------------------------------------
// Use: send boxes on the in channel (valid/ready), one request per cycle while
// idle; last_candidate closes the set. Boxes beyond MAX_BOXES are ignored.
// The boxes sit in a ring of MAX_BOXES cells that rotates past one overlap
// pipeline. Processing a set of n boxes takes one score lap, n compare laps
// and one output lap, each a full turn of the ring, with a drain of the
// overlap pipeline between the last compare lap and the output lap.
// Survivors leave on the out channel in index order, passing through the
// result pipeline; last_result marks the final one, and a set with no
// survivor gives one result with none_kept set. A stalled receiver holds the
// result register and stops the output lap; in_ready stays low until the
// output lap has passed. Configuration is written through cfg_write_en,
// cfg_index and cfg_data at any edge. Reset clears the thresholds to their
// defaults, empties the ring and returns to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module box_overlap_suppression import bos_pkg::*; #(
  parameter int MAX_BOXES       = MAX_BOXES_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [EDGE_W-1:0] top_edge,
  input  logic signed [EDGE_W-1:0] left_edge,
  input  logic signed [EDGE_W-1:0] bottom_edge,
  input  logic signed [EDGE_W-1:0] right_edge,
  input  logic [SCORE_W-1:0]    score,
  input  logic [LABEL_W-1:0]    class_label,
  input  logic                  last_candidate,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_W-1:0]    cand_index,
  output logic                  none_kept,
  output logic                  is_person,
  output logic [ROI_W-1:0]      roi_x,
  output logic [ROI_W-1:0]      roi_y,
  output logic [ROI_W-1:0]      roi_w,
  output logic [ROI_W-1:0]      roi_h,
  output logic [PCT_W-1:0]      score_percent,
  output logic                  last_result,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "box_overlap_suppression_assert.svh"

  localparam int TAG_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  bos_state_t          state, state_next;

  logic [THR_W-1:0]    score_thr, iou_thr, contain_thr;
  logic [FRAME_W-1:0]  frame_w, frame_h;

  bos_box_t            new_box;
  bos_box_t            box_q   [MAX_BOXES];
  bos_box_t            nb_box  [MAX_BOXES];
  logic [TAG_W-1:0]    tag_q   [MAX_BOXES];
  logic [TAG_W-1:0]    nb_tag  [MAX_BOXES];
  logic [MAX_BOXES-1:0] used_q, nb_used;

  logic [CNT_W-1:0]    box_count;
  logic [TAG_W-1:0]    rot_cnt;
  logic [CNT_W-1:0]    lap_k;
  logic                lap_end;

  logic                accept, load, start;
  logic                rotate, score_wr, issue, push, clear_set;
  logic                res_ready;

  bos_box_t            ref_box, nxt_box, nxt_sel;
  logic [CNT_W-1:0]    target;
  logic                capture;

  logic [MAX_BOXES-1:0] dropped, kept, kept_sh;
  logic                none_all, head_last;
  bos_rec_t            rec;

  logic                ovl_wr_en, ovl_busy;
  logic [TAG_W-1:0]    ovl_wr_tag, ovl_wr_ref;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr   <= SCORE_THR_RST;
      iou_thr     <= IOU_THR_RST;
      contain_thr <= CONTAIN_THR_RST;
      frame_w     <= FRAME_W_RST;
      frame_h     <= FRAME_H_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_SCORE_THR:   score_thr   <= cfg_data[THR_W-1:0];
        REG_IOU_THR:     iou_thr     <= cfg_data[THR_W-1:0];
        REG_CONTAIN_THR: contain_thr <= cfg_data[THR_W-1:0];
        REG_FRAME_W:     frame_w     <= cfg_data[FRAME_W-1:0];
        REG_FRAME_H:     frame_h     <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Request acceptance
  assign accept  = in_valid && in_ready;
  assign load    = accept && (box_count < CNT_W'(MAX_BOXES));
  assign start   = accept && last_candidate;
  assign lap_end = (rot_cnt == TAG_W'(MAX_BOXES - 1));

  assign new_box.top    = top_edge;
  assign new_box.left   = left_edge;
  assign new_box.bottom = bottom_edge;
  assign new_box.right  = right_edge;
  assign new_box.score  = score;
  assign new_box.label  = class_label;

  // Ring of cells: load shifts in at the tail, rotation wraps the head round
  genvar g;
  generate
    for (g = 0; g < MAX_BOXES; g++) begin : g_cell
      if (g == MAX_BOXES - 1) begin : g_tail
        assign nb_box[g]  = load ? new_box : box_q[0];
        assign nb_tag[g]  = load ? box_count[TAG_W-1:0] : tag_q[0];
        assign nb_used[g] = load ? 1'b1 : used_q[0];
      end else begin : g_body
        assign nb_box[g]  = box_q[g+1];
        assign nb_tag[g]  = tag_q[g+1];
        assign nb_used[g] = used_q[g+1];
      end

      bos_cell #(
        .TAG_W (TAG_W)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (rotate || load),
        .clear   (clear_set),
        .nb_box  (nb_box[g]),
        .nb_tag  (nb_tag[g]),
        .nb_used (nb_used[g]),
        .box     (box_q[g]),
        .tag     (tag_q[g]),
        .used    (used_q[g])
      );

      assign kept[g] = !dropped[g] && (CNT_W'(g) < box_count);
    end
  endgenerate

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCORE;
      end
      ST_SCORE: begin
        if (lap_end) state_next = (box_count == '0) ? ST_DRAIN : ST_CMP;
      end
      ST_CMP: begin
        if (lap_end && (lap_k == CNT_W'(box_count - 1'b1))) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!ovl_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (lap_end && res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    rotate    = 1'b0;
    score_wr  = 1'b0;
    issue     = 1'b0;
    push      = 1'b0;
    clear_set = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCORE: begin
        rotate   = 1'b1;
        score_wr = used_q[0];
      end
      ST_CMP: begin
        rotate = 1'b1;
        issue  = used_q[0] && (CNT_W'(tag_q[0]) > lap_k);
      end
      ST_DRAIN: ;
      ST_EMIT: begin
        rotate    = res_ready;
        push      = (used_q[0] && kept[tag_q[0]]) || (none_all && (rot_cnt == '0));
        clear_set = lap_end && res_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Rotation and lap counters, box count
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cnt   <= '0;
      lap_k     <= '0;
      box_count <= '0;
    end else begin
      if (rotate) rot_cnt <= lap_end ? '0 : rot_cnt + 1'b1;
      if (state == ST_SCORE && lap_end) begin
        lap_k <= '0;
      end else if (state == ST_CMP && lap_end) begin
        lap_k <= lap_k + 1'b1;
      end
      if (clear_set) begin
        box_count <= '0;
      end else if (load) begin
        box_count <= box_count + 1'b1;
      end
    end
  end

  // Capture the next reference box as it passes the head
  assign target  = (state == ST_SCORE) ? '0 : lap_k + 1'b1;
  assign capture = used_q[0] && (CNT_W'(tag_q[0]) == target);
  assign nxt_sel = capture ? box_q[0] : nxt_box;

  always_ff @(posedge clk) begin
    if (state == ST_SCORE || state == ST_CMP) begin
      nxt_box <= nxt_sel;
      if (lap_end) ref_box <= nxt_sel;
    end
  end

  // Overlap pipeline
  bos_overlap #(
    .TAG_W (TAG_W)
  ) u_overlap (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .ref_tag     (lap_k[TAG_W-1:0]),
    .cand_tag    (tag_q[0]),
    .ref_box     (ref_box),
    .cand_box    (box_q[0]),
    .iou_thr     (iou_thr),
    .contain_thr (contain_thr),
    .wr_en       (ovl_wr_en),
    .wr_tag      (ovl_wr_tag),
    .wr_ref      (ovl_wr_ref),
    .busy        (ovl_busy)
  );

  // Dropped flags: score drops on the first lap, suppression from kept refs
  always_ff @(posedge clk) begin
    if (rst || start) begin
      dropped <= '0;
    end else begin
      if (score_wr) dropped[tag_q[0]] <= (box_q[0].score < score_thr);
      if (ovl_wr_en && !dropped[ovl_wr_ref]) dropped[ovl_wr_tag] <= 1'b1;
    end
  end

  // Survivor bookkeeping for the output lap
  assign none_all  = (kept == '0);
  assign kept_sh   = kept >> tag_q[0];
  assign head_last = ~|kept_sh[MAX_BOXES-1:1];

  assign rec.box   = box_q[0];
  assign rec.index = none_all ? '0 : INDEX_W'(tag_q[0]);
  assign rec.none  = none_all;
  assign rec.last  = none_all || head_last;

  bos_result #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_result (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .ready         (res_ready),
    .rec           (rec),
    .frame_w       (frame_w),
    .frame_h       (frame_h),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cand_index    (cand_index),
    .none_kept     (none_kept),
    .is_person     (is_person),
    .roi_x         (roi_x),
    .roi_y         (roi_y),
    .roi_w         (roi_w),
    .roi_h         (roi_h),
    .score_percent (score_percent),
    .last_result   (last_result)
  );

  // Assertions
  `BOS_ASSERT_HOLDS(a_wr_later, clk, rst, ovl_wr_en, ovl_wr_tag > ovl_wr_ref, "suppression of an earlier box")
  `BOS_ASSERT_HOLDS(a_emit_drained, clk, rst, state == ST_EMIT, !ovl_busy, "output lap with overlap tests in flight")
  `BOS_ASSERT_HOLDS(a_none_last, clk, rst, out_valid && none_kept, last_result, "empty result not marked last")
  `BOS_ASSERT_NEXT(a_set_starts, clk, rst, start, state == ST_SCORE, "closing request did not start processing")
  `BOS_ASSERT_HOLDS(a_count_bound, clk, rst, 1'b1, box_count <= CNT_W'(MAX_BOXES), "box count beyond store")

endmodule

`default_nettype wire
